>>> rtl/ffpa_pkg.sv
// Shared types and constants for the first-fit page run allocator.
package ffpa_pkg;

  localparam int TOTAL_PAGES = 1024;
  localparam int PAGE_W      = $clog2(TOTAL_PAGES);
  localparam int LEN_W       = PAGE_W + 1;
  localparam int IDX_W       = PAGE_W + 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    command_t            command;
    logic [LEN_W-1:0]    req_pages;
    logic [PAGE_W-1:0]   free_page;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   run_start;
    logic [LEN_W-1:0]    run_pages;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_FREE_CLR
  } state_t;

endpackage

>>> rtl/ffpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/first_fit_page_run_allocator_unit.sv
// Top level of the first-fit page run allocator: control sequencer around the run length map.
//
// Usage:
//   Commands enter on cmd with start; a command is taken at an edge where start is
//   high and busy is low. Each command yields exactly one result on result, flagged
//   by done for one cycle; the receiver cannot stall it, so it must take it then.
//   start_page is written on the cfg channel (cfg_valid/cfg_ready, always ready)
//   and must only change while the block is idle.
// Steps (every result is registered, so it shows in the cycle after the last step):
//   Zero-page allocate, allocate with start_page past the map, and free below
//   start_page: answered directly from the idle state.
//   Allocate: the first-fit scan visits one map entry per step (free pages are
//   stepped one at a time, allocated runs are jumped in one step), plus one more
//   step when the scan runs off the map end.
//   Free: a check of the page, then one map write per page of the run (run
//   clipped at the map end); a free of a page that starts no run ends after the check.
// The single map port pair sets the rate: one map read or write per cycle, and the
// next command is taken only after the current one finishes.
// Reset: the map is cleared by a pass over all TOTAL_PAGES (1024) entries with busy high;
// start_page resets to 0 and configuration writes are taken during the pass.
module first_fit_page_run_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  ffpa_pkg::cmd_t            cmd,
  output logic                      done,
  output ffpa_pkg::res_t            result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ffpa_pkg::LEN_W-1:0] cfg_data
);

  import ffpa_pkg::*;

  localparam logic [IDX_W-1:0] MAP_END  = IDX_W'(TOTAL_PAGES);
  localparam logic [LEN_W-1:0] LEN_END  = LEN_W'(TOTAL_PAGES);
  localparam logic [PAGE_W-1:0] LAST_PG = PAGE_W'(TOTAL_PAGES - 1);

  state_t              state, state_next;
  logic [LEN_W-1:0]    start_page;
  logic [PAGE_W-1:0]   clr, clr_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [LEN_W-1:0]    found, found_next;
  logic [PAGE_W-1:0]   cand, cand_next;
  logic [LEN_W-1:0]    want, want_next;
  logic [PAGE_W-1:0]   page, page_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [LEN_W-1:0]    k, k_next;
  logic                done_next;
  res_t                result_next;

  logic                mem_we;
  logic [PAGE_W-1:0]   mem_waddr;
  logic [LEN_W-1:0]    mem_wdata;
  logic [PAGE_W-1:0]   mem_raddr;
  logic [LEN_W-1:0]    mem_rdata;

  logic                accept;
  logic                alloc_quick;
  logic                free_quick;
  logic                scan_end;
  logic                scan_hit;
  logic [LEN_W-1:0]    found_inc;
  logic [IDX_W-1:0]    clr_addr;
  logic                clr_go;

  // Run length map
  ffpa_ram #(
    .WIDTH (LEN_W),
    .DEPTH (TOTAL_PAGES)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and shared decisions
  assign busy        = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = start && (state == ST_IDLE);
  assign alloc_quick = (cmd.req_pages == '0) || (start_page >= LEN_END);
  assign free_quick  = ({1'b0, cmd.free_page} < start_page);
  assign scan_end    = (idx >= MAP_END);
  assign found_inc   = found + LEN_W'(1);
  assign scan_hit    = (mem_rdata == '0) && (found_inc == want);
  assign clr_addr    = {2'b00, page} + {1'b0, k};
  assign clr_go      = (k < len) && (clr_addr < MAP_END);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == LAST_PG) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd.command == CMD_ALLOC) begin
            if (!alloc_quick) begin
              state_next = ST_SCAN;
            end
          end else if (!free_quick) begin
            state_next = ST_FREE_CHK;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end || scan_hit) begin
          state_next = ST_IDLE;
        end
      end
      ST_FREE_CHK: begin
        if (mem_rdata == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FREE_CLR;
        end
      end
      ST_FREE_CLR: begin
        if (!clr_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Map accesses, datapath and result
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    clr_next    = clr;
    idx_next    = idx;
    found_next  = found;
    cand_next   = cand;
    want_next   = want;
    page_next   = page;
    len_next    = len;
    k_next      = k;
    done_next   = 1'b0;
    result_next = result;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        clr_next  = clr + PAGE_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          page_next = cmd.free_page;
          if (cmd.command == CMD_ALLOC) begin
            if (alloc_quick) begin
              done_next   = 1'b1;
              result_next = '{status: STAT_NOSPACE, run_start: '0, run_pages: '0};
            end else begin
              mem_raddr  = start_page[PAGE_W-1:0];
              idx_next   = {1'b0, start_page};
              found_next = '0;
              want_next  = cmd.req_pages;
            end
          end else if (free_quick) begin
            done_next   = 1'b1;
            result_next = '{status: STAT_IGNORED, run_start: cmd.free_page,
                            run_pages: '0};
          end else begin
            mem_raddr = cmd.free_page;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          done_next   = 1'b1;
          result_next = '{status: STAT_NOSPACE, run_start: '0, run_pages: '0};
        end else if (mem_rdata == '0) begin
          // Count a free page; claim the stretch once it is long enough
          if (found == '0) begin
            cand_next = idx[PAGE_W-1:0];
          end
          if (scan_hit) begin
            mem_we      = 1'b1;
            mem_waddr   = (found == '0) ? idx[PAGE_W-1:0] : cand;
            mem_wdata   = want;
            done_next   = 1'b1;
            result_next = '{status: STAT_OK,
                            run_start: (found == '0) ? idx[PAGE_W-1:0] : cand,
                            run_pages: want};
          end else begin
            found_next = found_inc;
            idx_next   = idx + IDX_W'(1);
            mem_raddr  = idx_next[PAGE_W-1:0];
          end
        end else begin
          // Jump over an allocated run
          found_next = '0;
          idx_next   = idx + {1'b0, mem_rdata};
          mem_raddr  = idx_next[PAGE_W-1:0];
        end
      end
      ST_FREE_CHK: begin
        if (mem_rdata == '0) begin
          done_next   = 1'b1;
          result_next = '{status: STAT_IGNORED, run_start: page, run_pages: '0};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = page;
          len_next  = mem_rdata;
          k_next    = LEN_W'(1);
        end
      end
      ST_FREE_CLR: begin
        if (clr_go) begin
          mem_we    = 1'b1;
          mem_waddr = clr_addr[PAGE_W-1:0];
          k_next    = k + LEN_W'(1);
        end else begin
          done_next   = 1'b1;
          result_next = '{status: STAT_OK, run_start: page, run_pages: len};
        end
      end
      default: begin
        clr_next = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      done       <= 1'b0;
      start_page <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        start_page <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    found  <= found_next;
    cand   <= cand_next;
    want   <= want_next;
    page   <= page_next;
    len    <= len_next;
    k      <= k_next;
    result <= result_next;
  end

endmodule

>>> bench/tb.sv
// Self-checking testbench for the first-fit page run allocator: directed rows, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpa_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int ITEMS_PER_PHASE = 100;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [LEN_W-1:0] cfg_value;
    cmd_t             c;
    bit               fixed;
    res_t             fixed_res;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd = '0;
  logic             done;
  res_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  // Shadow copy of the allocator state
  logic [LEN_W-1:0] page_map [TOTAL_PAGES];
  logic [LEN_W-1:0] region_start = '0;

  res_t      awaited_results [$];
  plan_row_t directed_plan [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        no_gap_left = 0;

  first_fit_page_run_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Apply one command to the shadow map and return the result it must produce
  function automatic res_t expected_page_result(input cmd_t c);
    res_t r;
    int   idx;
    int   found;
    int   cand;
    int   want;
    int   pg;
    int   len;
    r.status    = STAT_NOSPACE;
    r.run_start = '0;
    r.run_pages = '0;
    if (c.command == CMD_ALLOC) begin
      want  = int'(c.req_pages);
      idx   = int'(region_start);
      found = 0;
      cand  = 0;
      if (want == 0) return r;
      while (idx < TOTAL_PAGES) begin
        if (page_map[idx] == '0) begin
          found++;
          if (found == 1) cand = idx;
          if (found == want) begin
            page_map[cand] = LEN_W'(want);
            r.status    = STAT_OK;
            r.run_start = PAGE_W'(cand);
            r.run_pages = LEN_W'(want);
            return r;
          end
          idx++;
        end else begin
          found = 0;
          idx += int'(page_map[idx]);
        end
      end
      return r;
    end
    pg = int'(c.free_page);
    r.run_start = c.free_page;
    if (pg < int'(region_start) || page_map[pg] == '0) begin
      r.status = STAT_IGNORED;
      return r;
    end
    len = int'(page_map[pg]);
    for (int k = 0; k < len && pg + k < TOTAL_PAGES; k++) page_map[pg + k] = '0;
    r.status    = STAT_OK;
    r.run_pages = LEN_W'(len);
    return r;
  endfunction

  function automatic plan_row_t row_alloc(input int n);
    plan_row_t r;
    r = '{kind: ROW_CMD, cfg_value: '0, c: '0, fixed: 1'b0, fixed_res: '0};
    r.c.command   = CMD_ALLOC;
    r.c.req_pages = LEN_W'(n);
    return r;
  endfunction

  function automatic plan_row_t row_free(input int p);
    plan_row_t r;
    r = '{kind: ROW_CMD, cfg_value: '0, c: '0, fixed: 1'b0, fixed_res: '0};
    r.c.command   = CMD_FREE;
    r.c.free_page = PAGE_W'(p);
    return r;
  endfunction

  function automatic plan_row_t row_cfg(input int v);
    plan_row_t r;
    r = '{kind: ROW_CFG, cfg_value: LEN_W'(v), c: '0, fixed: 1'b0, fixed_res: '0};
    return r;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t r, input status_t s,
                                            input int first, input int n);
    plan_row_t o;
    o = r;
    o.fixed               = 1'b1;
    o.fixed_res.status    = s;
    o.fixed_res.run_start = PAGE_W'(first);
    o.fixed_res.run_pages = LEN_W'(n);
    return o;
  endfunction

  // Mostly no gap or a short one, a few long ones, and occasional stretches with none
  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      no_gap_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Well-formed alloc/free traffic with some noise mixed in
  function automatic cmd_t random_page_command();
    cmd_t c;
    int   r;
    int   s;
    int   live [$];
    c.command   = CMD_ALLOC;
    c.req_pages = LEN_W'(1);
    c.free_page = PAGE_W'($urandom_range(0, TOTAL_PAGES - 1));
    for (int p = 0; p < TOTAL_PAGES; p++)
      if (page_map[p] != '0 && p >= int'(region_start)) live.push_back(p);
    r = $urandom_range(0, 99);
    if (r < 35 && live.size() > 0) begin
      c.command   = CMD_FREE;
      c.free_page = PAGE_W'(live[$urandom_range(0, live.size() - 1)]);
    end else if (r < 80) begin
      s = $urandom_range(0, 99);
      if (s < 80)      c.req_pages = LEN_W'($urandom_range(1, 16));
      else if (s < 95) c.req_pages = LEN_W'($urandom_range(17, 128));
      else if (s < 99) c.req_pages = LEN_W'($urandom_range(129, TOTAL_PAGES - 1));
      else             c.req_pages = LEN_W'(TOTAL_PAGES);
    end else begin
      s = $urandom_range(0, 2);
      if (s == 0)      c.command   = CMD_FREE;
      else if (s == 1) c.req_pages = '0;
      else             c.req_pages = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
    end
    return c;
  endfunction

  // Present one command, wait until it is taken, then queue its expected result
  task automatic issue_command(input cmd_t c, input bit has_fixed, input res_t fixed_res);
    res_t predicted;
    int   gap;
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = expected_page_result(c);
    awaited_results.push_back(has_fixed ? fixed_res : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_off();
    start <= 1'b0;
  endtask

  // Write start_page once the block is idle and drained
  task automatic write_start_page(input logic [LEN_W-1:0] v);
    do @(posedge clk); while (awaited_results.size() != 0 || busy);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    region_start  = v;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d run_start=%0d run_pages=%0d",
                   result.status, result.run_start, result.run_pages);
      end else begin
        exp_res = awaited_results.pop_front();
        if (result.status !== exp_res.status || result.run_start !== exp_res.run_start ||
            result.run_pages !== exp_res.run_pages) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d run_start=%0d run_pages=%0d, got %0d %0d %0d",
                     exp_res.status, exp_res.run_start, exp_res.run_pages,
                     result.status, result.run_start, result.run_pages);
        end
      end
    end
  end

  initial begin
    logic [LEN_W-1:0] phase_start [4];
    plan_row_t        row;
    for (int p = 0; p < TOTAL_PAGES; p++) page_map[p] = '0;

    // Directed rows: extremes, error codes and the scan corner cases
    directed_plan.push_back(with_result(row_alloc(1), STAT_OK, 0, 1));
    directed_plan.push_back(with_result(row_alloc(TOTAL_PAGES), STAT_NOSPACE, 0, 0));
    directed_plan.push_back(with_result(row_alloc(0), STAT_NOSPACE, 0, 0));
    directed_plan.push_back(with_result(row_free(0), STAT_OK, 0, 1));
    directed_plan.push_back(with_result(row_free(0), STAT_IGNORED, 0, 0));
    directed_plan.push_back(with_result(row_alloc(TOTAL_PAGES), STAT_OK, 0, TOTAL_PAGES));
    directed_plan.push_back(with_result(row_alloc(1), STAT_NOSPACE, 0, 0));
    directed_plan.push_back(with_result(row_free(TOTAL_PAGES - 1), STAT_IGNORED,
                                        TOTAL_PAGES - 1, 0));
    directed_plan.push_back(with_result(row_free(0), STAT_OK, 0, TOTAL_PAGES));
    directed_plan.push_back(row_alloc(5));
    directed_plan.push_back(row_alloc(3));
    directed_plan.push_back(with_result(row_alloc((1 << LEN_W) - 1), STAT_NOSPACE, 0, 0));
    directed_plan.push_back(row_free(5));
    directed_plan.push_back(row_alloc(2));
    // Region starts past the map
    directed_plan.push_back(row_cfg(TOTAL_PAGES));
    directed_plan.push_back(with_result(row_alloc(1), STAT_NOSPACE, 0, 0));
    directed_plan.push_back(with_result(row_free(0), STAT_IGNORED, 0, 0));
    // Region of one page at the top of the map
    directed_plan.push_back(row_cfg(TOTAL_PAGES - 1));
    directed_plan.push_back(row_alloc(1));
    directed_plan.push_back(row_alloc(2));
    directed_plan.push_back(row_free(TOTAL_PAGES - 1));
    // Region starts inside an allocated run
    directed_plan.push_back(row_cfg(3));
    directed_plan.push_back(row_alloc(2));
    directed_plan.push_back(row_free(0));
    directed_plan.push_back(row_free(3));
    directed_plan.push_back(row_cfg(0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        hold_off();
        write_start_page(row.cfg_value);
      end else begin
        issue_command(row.c, row.fixed, row.fixed_res);
      end
    end

    // Random phases under several region starts
    phase_start[0] = '0;
    phase_start[1] = LEN_W'($urandom_range(1, 300));
    phase_start[2] = LEN_W'($urandom_range(900, TOTAL_PAGES - 1));
    phase_start[3] = '0;
    for (int ph = 0; ph < 4; ph++) begin
      hold_off();
      write_start_page(phase_start[ph]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) issue_command(random_page_command(), 1'b0, '0);
    end

    // Drain and report
    hold_off();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
